// ----- hdl/cdq_pkg.sv -----
`default_nettype none

package cdq_pkg;

    localparam int KIND_W  = 4;
    localparam int POS_W   = 10;
    localparam int VALUE_W = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    typedef enum logic [KIND_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_READ       = 4'd4,
        OP_WRITE      = 4'd5,
        OP_LSEARCH    = 4'd6,
        OP_BSEARCH    = 4'd7,
        OP_CLEAR      = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     found;
        logic [POS_W-1:0]         found_position;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
    } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/cdq_req_if.sv -----
`default_nettype none

interface cdq_req_if;
    import cdq_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/cdq_rsp_if.sv -----
`default_nettype none

interface cdq_rsp_if;
    import cdq_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/circular_deque_with_search.sv -----
`default_nettype none

// Circular deque of DEPTH signed words of WORD_BITS bits with linear and binary
// search. One request word in gives exactly one response word out, in order.
// The words live in a single synchronous RAM (one write or one read per cycle),
// so the RAM port sets the timing: push, pop, read, write, clear and unused
// kinds go from idle straight to the finish state. A linear search stops at
// the first match or after count compares when the key is absent (one word read
// per cycle), and a binary search passes an address and a compare state per
// probe. A finished response is held in an output register, so a new request
// is taken while the last response still waits. The RAM is not cleared after
// reset; entries are only read after they were written. Response count and
// found_position are the low 11 and 10 bits of the internal values.
module circular_deque_with_search #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    cdq_req_if.sink    req,
    cdq_rsp_if.source  rsp
);
    import cdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LR_W  = CNT_W + 1;

    localparam logic [PTR_W:0]   DEPTH_X = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL    = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIN,
        S_LIN,
        S_BADDR,
        S_BCMP
    } state_t;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] ofs);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[PTR_W-1:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [PTR_W-1:0]        slot_reg, slot_next;
    logic [PTR_W-1:0]        idx_reg, idx_next;
    logic [PTR_W-1:0]        mid_reg, mid_next;
    logic signed [LR_W-1:0]  left_reg, left_next;
    logic signed [LR_W-1:0]  right_reg, right_next;
    logic signed [WORD_BITS-1:0] key_reg, key_next;
    logic                    use_rd_reg, use_rd_next;
    logic                    found_reg, found_next;
    logic [POS_W-1:0]        fpos_reg, fpos_next;
    status_t                 status_reg, status_next;
    logic                    out_valid_reg, out_valid_next;
    rsp_t                    out_reg, out_next;

    logic [WORD_BITS-1:0]    mem [DEPTH];
    logic [WORD_BITS-1:0]    rd_data;
    logic                    we, re;
    logic [PTR_W-1:0]        waddr, raddr;
    logic [WORD_BITS-1:0]    wdata;

    logic signed [WORD_BITS-1:0] word;
    logic signed [WORD_BITS-1:0] rd_word;
    logic [PTR_W-1:0]        logical;
    logic [PTR_W-1:0]        slot;
    logic [PTR_W-1:0]        head_dec;
    logic [LR_W:0]           mid_sum;
    logic                    is_full, is_empty, pos_bad;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    assign word     = WORD_BITS'(req.payload.value);
    assign rd_word  = $signed(rd_data);
    assign is_full  = (count_reg == FULL);
    assign is_empty = (count_reg == '0);
    assign pos_bad  = (CMP_W'(req.payload.position) >= CMP_W'(count_reg));
    assign head_dec = (head_reg == '0) ? LAST : head_reg - 1'b1;
    assign mid_sum  = {1'b0, left_reg} + {1'b0, right_reg};

    always_comb
    begin
        case (req.payload.kind)
            OP_PUSH_BACK: logical = count_reg[PTR_W-1:0];
            OP_POP_BACK:  logical = PTR_W'(count_reg - 1'b1);
            OP_READ,
            OP_WRITE:     logical = PTR_W'(req.payload.position);
            default:      logical = '0;
        endcase
    end

    assign slot = wrap_add(head_reg, logical);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        mid_next       = mid_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        key_next       = key_reg;
        use_rd_next    = use_rd_reg;
        found_next     = found_reg;
        fpos_next      = fpos_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = slot;
        raddr          = slot;
        wdata          = word;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next    = word;
                    use_rd_next = 1'b0;
                    found_next  = 1'b0;
                    fpos_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    case (req.payload.kind)
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                re          = 1'b1;
                                use_rd_next = 1'b1;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                re          = 1'b1;
                                raddr       = head_reg;
                                use_rd_next = 1'b1;
                                head_next   = (head_reg == LAST) ? '0 : head_reg + 1'b1;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                re          = 1'b1;
                                use_rd_next = 1'b1;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (pos_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                we = 1'b1;
                            end
                        end
                        OP_LSEARCH:
                        begin
                            if (!is_empty)
                            begin
                                re         = 1'b1;
                                raddr      = head_reg;
                                slot_next  = wrap_add(head_reg, PTR_W'(1));
                                idx_next   = '0;
                                state_next = S_LIN;
                            end
                        end
                        OP_BSEARCH:
                        begin
                            left_next  = '0;
                            right_next = $signed(LR_W'(count_reg) - LR_W'(1));
                            state_next = S_BADDR;
                        end
                        OP_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_LIN:
            begin
                if (rd_word == key_reg)
                begin
                    found_next = 1'b1;
                    fpos_next  = POS_W'(idx_reg);
                    state_next = S_FIN;
                end
                else if (CNT_W'(idx_reg) == count_reg - 1'b1)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    re        = 1'b1;
                    raddr     = slot_reg;
                    slot_next = wrap_add(slot_reg, PTR_W'(1));
                    idx_next  = idx_reg + 1'b1;
                end
            end

            S_BADDR:
            begin
                if (left_reg > right_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    mid_next   = PTR_W'(mid_sum[LR_W:1]);
                    re         = 1'b1;
                    raddr      = wrap_add(head_reg, PTR_W'(mid_sum[LR_W:1]));
                    state_next = S_BCMP;
                end
            end

            S_BCMP:
            begin
                state_next = S_BADDR;
                if (rd_word < key_reg)
                begin
                    left_next = $signed(LR_W'(mid_reg) + LR_W'(1));
                end
                else if (rd_word > key_reg)
                begin
                    right_next = $signed(LR_W'(mid_reg) - LR_W'(1));
                end
                else
                begin
                    found_next = 1'b1;
                    fpos_next  = POS_W'(mid_reg);
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next.data           = use_rd_reg ? DATA_W'(rd_word) : '0;
                    out_next.found          = found_reg;
                    out_next.found_position = fpos_reg;
                    out_next.count          = COUNT_W'(count_reg);
                    out_next.status         = status_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            mid_reg       <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            key_reg       <= '0;
            use_rd_reg    <= 1'b0;
            found_reg     <= 1'b0;
            fpos_reg      <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            mid_reg       <= mid_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            key_reg       <= key_next;
            use_rd_reg    <= use_rd_next;
            found_reg     <= found_next;
            fpos_reg      <= fpos_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data <= mem[raddr];
        end
    end

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in flight");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && count_reg != FULL &&
         (req.payload.kind == OP_PUSH_BACK || req.payload.kind == OP_PUSH_FRONT))
        |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("push did not grow the count by one");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIN) |-> (count_reg != '0 && CNT_W'(idx_reg) < count_reg))
        else $error("linear scan index past the stored count");

endmodule

`default_nettype wire
